// File: src/pnls_pkg.sv
// Shared constants, codes and controller/datapath interface types for the path search block.
package pnls_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int AW         = $clog2(MAX_POINTS);  // waypoint index width
    localparam int LW         = 13;                  // path_length register width
    localparam int CW         = 24;                  // coordinate width, signed Q15.8
    localparam int DIFW       = CW + 1;              // coordinate difference width
    localparam int SQW        = 2 * DIFW;            // squared difference width
    localparam int DSW        = SQW + 1;             // squared distance width
    localparam int RW         = 16;                  // widest configuration register
    localparam int RSQW       = 2 * RW;              // squared radius width
    localparam int CIW        = 3;                   // configuration index width
    localparam int KW         = 2;                   // item kind width

    localparam logic [KW-1:0] KIND_WRITE = 2'd0;
    localparam logic [KW-1:0] KIND_QUERY = 2'd1;
    localparam logic [KW-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CIW-1:0] CFG_PATH_LEN  = 3'd0;
    localparam logic [CIW-1:0] CFG_LOOKAHEAD = 3'd1;
    localparam logic [CIW-1:0] CFG_JUMP      = 3'd2;
    localparam logic [CIW-1:0] CFG_BACK_WIN  = 3'd3;
    localparam logic [CIW-1:0] CFG_FWD_WIN   = 3'd4;

    localparam logic [RW-1:0] JUMP_RST = 16'd25600;
    localparam logic [11:0]   BACK_RST = 12'd100;
    localparam logic [11:0]   FWD_RST  = 12'd200;

    typedef struct packed {
        logic wr;           // store a waypoint
        logic clr_hint;     // clear the search hint
        logic latch_query;  // capture the vehicle position
        logic load_hint;    // point the read address at the hint
        logic set_full;     // search range = whole path
        logic set_window;   // search range = window around the hint
        logic start_look;   // commit nearest, range = nearest .. end of path
        logic issue;        // read one waypoint into the distance pipeline
        logic take_best;    // keep the current distance as the best one
        logic emit;         // post a search result
        logic emit_empty;   // post an empty-path result
        logic flush;        // drop reads still in flight
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic hint_full;
        logic issue_last;
        logic dist_valid;
        logic dist_last;
        logic near_better;
        logic la_hit;
        logic jump_far;
    } t_status;

endpackage

// File: src/path_nearest_and_lookahead_search_top.sv
// Top level of the nearest-waypoint and lookahead path search block.
//
// Accepts one item at a rising edge where start is high and busy is low. A
// waypoint write, a hint clear or an unused kind gives no result and leaves
// busy low. A query reads waypoints from a 4096-entry memory, one per cycle,
// through a four-stage distance pipeline (read, difference, square, sum), so
// its length is set by that single read port. Its result strobe ends at the
// edge at which the next item can transfer. The nearest search covers the
// whole path or the hint window, and the lookahead search walks forward from
// the nearest point up to and including the lookahead point. A query with a
// nonzero hint inside the path checks the hint distance first and falls back
// to a full scan when that point is farther than the jump distance. A query on
// an empty path posts its result in the cycle right after it transfers. Each
// result is on o_nearest_index, o_lookahead_index and o_path_empty for exactly
// one cycle, marked by o_result_valid; the receiver cannot hold results off,
// so capture it in that cycle. Configuration writes transfer when i_cfg_valid
// and o_cfg_ready are high; ready is low while a query runs and while start is
// high. The waypoint memory is not cleared at reset: write every slot in use
// first.
module path_nearest_and_lookahead_search_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pnls_pkg::KW-1:0]           i_kind,
    input  logic [pnls_pkg::AW-1:0]           i_point_index,
    input  logic signed [pnls_pkg::CW-1:0]    i_pos_x,
    input  logic signed [pnls_pkg::CW-1:0]    i_pos_y,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pnls_pkg::CIW-1:0]          i_cfg_index,
    input  logic [pnls_pkg::RW-1:0]           i_cfg_data,
    output logic                              o_result_valid,
    output logic [pnls_pkg::AW-1:0]           o_nearest_index,
    output logic [pnls_pkg::AW-1:0]           o_lookahead_index,
    output logic                              o_path_empty
);
    import pnls_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_cfg_we;

    // hold off configuration while a query is running or an item is offered
    assign o_cfg_ready = !busy && !start;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    pnls_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_kind   (i_kind),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    pnls_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_point_index     (i_point_index),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_cfg_we          (w_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_result_valid    (o_result_valid),
        .o_nearest_index   (o_nearest_index),
        .o_lookahead_index (o_lookahead_index),
        .o_path_empty      (o_path_empty)
    );

endmodule

// File: src/pnls_datapath.sv
// Datapath: configuration registers, waypoint memory, distance pipeline and search registers.
module pnls_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pnls_pkg::t_cmd                    i_cmd,
    output pnls_pkg::t_status                 o_status,
    input  logic [pnls_pkg::AW-1:0]           i_point_index,
    input  logic signed [pnls_pkg::CW-1:0]    i_pos_x,
    input  logic signed [pnls_pkg::CW-1:0]    i_pos_y,
    input  logic                              i_cfg_we,
    input  logic [pnls_pkg::CIW-1:0]          i_cfg_index,
    input  logic [pnls_pkg::RW-1:0]           i_cfg_data,
    output logic                              o_result_valid,
    output logic [pnls_pkg::AW-1:0]           o_nearest_index,
    output logic [pnls_pkg::AW-1:0]           o_lookahead_index,
    output logic                              o_path_empty
);
    import pnls_pkg::*;

    // configuration
    logic [LW-1:0]   r_path_len;
    logic [RW-1:0]   r_la_dist;
    logic [RW-1:0]   r_jump_dist;
    logic [11:0]     r_back_win;
    logic [11:0]     r_fwd_win;
    logic [RSQW-1:0] r_la_sq;
    logic [RSQW-1:0] r_jump_sq;

    // search control
    logic [AW-1:0]   r_hint;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_hi;
    logic            r_have_best;
    logic [DSW-1:0]  r_best;
    logic [AW-1:0]   r_nearest;
    logic signed [CW-1:0] r_qx;
    logic signed [CW-1:0] r_qy;

    // waypoint memory and distance pipeline
    logic [2*CW-1:0] r_mem [MAX_POINTS];
    logic [2*CW-1:0] r_rd;
    logic            r_v1, r_v2, r_v3, r_v4;
    logic [AW-1:0]   r_idx1, r_idx2, r_idx3, r_idx4;
    logic signed [DIFW-1:0] r_dx, r_dy;
    logic signed [SQW-1:0]  r_sqx, r_sqy;
    logic [DSW-1:0]  r_dist;

    logic [LW-1:0]   w_len;
    logic [AW-1:0]   w_len_m1;
    logic [AW-1:0]   w_win_lo;
    logic [AW:0]     w_win_sum;
    logic [AW-1:0]   w_win_hi;
    logic [AW-1:0]   w_near_sel;
    logic signed [CW-1:0] w_rd_x, w_rd_y;

    assign w_len    = (r_path_len > LW'(MAX_POINTS)) ? LW'(MAX_POINTS) : r_path_len;
    assign w_len_m1 = AW'(w_len - LW'(1));
    assign w_win_lo = (r_hint > r_back_win) ? (r_hint - r_back_win) : '0;
    assign w_win_sum = {1'b0, r_hint} + {1'b0, r_fwd_win};
    assign w_win_hi = (w_win_sum > {1'b0, w_len_m1}) ? w_len_m1 : w_win_sum[AW-1:0];
    assign w_near_sel = i_cmd.take_best ? r_idx4 : r_nearest;
    assign w_rd_x = r_rd[2*CW-1:CW];
    assign w_rd_y = r_rd[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len  <= '0;
            r_la_dist   <= '0;
            r_jump_dist <= JUMP_RST;
            r_back_win  <= BACK_RST;
            r_fwd_win   <= FWD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATH_LEN:  r_path_len  <= i_cfg_data[LW-1:0];
                CFG_LOOKAHEAD: r_la_dist   <= i_cfg_data;
                CFG_JUMP:      r_jump_dist <= i_cfg_data;
                CFG_BACK_WIN:  r_back_win  <= i_cfg_data[11:0];
                CFG_FWD_WIN:   r_fwd_win   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_la_sq   <= r_la_dist * r_la_dist;
        r_jump_sq <= r_jump_dist * r_jump_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hint      <= '0;
            r_addr      <= '0;
            r_hi        <= '0;
            r_have_best <= 1'b0;
            r_nearest   <= '0;
        end else begin
            if (i_cmd.clr_hint) begin
                r_hint <= '0;
            end else if (i_cmd.start_look) begin
                r_hint <= w_near_sel;
            end

            priority if (i_cmd.load_hint) begin
                r_addr <= r_hint;
                r_hi   <= r_hint;
            end else if (i_cmd.set_full) begin
                r_addr <= '0;
                r_hi   <= w_len_m1;
            end else if (i_cmd.set_window) begin
                r_addr <= w_win_lo;
                r_hi   <= w_win_hi;
            end else if (i_cmd.start_look) begin
                r_addr <= w_near_sel;
                r_hi   <= w_len_m1;
            end else if (i_cmd.issue) begin
                r_addr <= r_addr + AW'(1);
            end

            if (i_cmd.set_full || i_cmd.set_window) begin
                r_have_best <= 1'b0;
            end else if (i_cmd.take_best) begin
                r_have_best <= 1'b1;
                r_nearest   <= r_idx4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_best) begin
            r_best <= r_dist;
        end
        if (i_cmd.latch_query) begin
            r_qx <= i_pos_x;
            r_qy <= i_pos_y;
        end
    end

    // waypoint memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_point_index] <= {i_pos_x, i_pos_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.flush) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_addr;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_idx4 <= r_idx3;
        r_dx   <= {r_qx[CW-1], r_qx} - {w_rd_x[CW-1], w_rd_x};
        r_dy   <= {r_qy[CW-1], r_qy} - {w_rd_y[CW-1], w_rd_y};
        r_sqx  <= r_dx * r_dx;
        r_sqy  <= r_dy * r_dy;
        r_dist <= {1'b0, r_sqx} + {1'b0, r_sqy};
    end

    always_comb begin
        o_status.len_zero    = (w_len == '0);
        o_status.hint_full   = (r_hint == '0) || ({1'b0, r_hint} >= w_len);
        o_status.issue_last  = (r_addr == r_hi);
        o_status.dist_valid  = r_v4;
        o_status.dist_last   = (r_idx4 == r_hi);
        o_status.near_better = !r_have_best || (r_dist < r_best);
        o_status.la_hit      = (r_dist >= {{(DSW-RSQW){1'b0}}, r_la_sq});
        o_status.jump_far    = (r_dist > {{(DSW-RSQW){1'b0}}, r_jump_sq});
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.emit || i_cmd.emit_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_empty) begin
            o_nearest_index   <= '0;
            o_lookahead_index <= '0;
            o_path_empty      <= 1'b1;
        end else if (i_cmd.emit) begin
            o_nearest_index   <= r_nearest;
            o_lookahead_index <= r_idx4;
            o_path_empty      <= 1'b0;
        end
    end

endmodule

// File: src/pnls_ctrl.sv
// Controller: sequences item decode, hint check, nearest scan and lookahead scan.
module pnls_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pnls_pkg::KW-1:0]    i_kind,
    input  pnls_pkg::t_status          i_status,
    output pnls_pkg::t_cmd             o_cmd,
    output logic                       o_busy
);
    import pnls_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_HINT_ISSUE = 5'b00010,
        S_HINT_WAIT  = 5'b00100,
        S_NEAR       = 5'b01000,
        S_LOOK       = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_issuing, n_issuing;

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issuing <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issuing <= n_issuing;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_issuing = r_issuing;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_kind)
                        KIND_WRITE: o_cmd.wr = 1'b1;
                        KIND_CLEAR: o_cmd.clr_hint = 1'b1;
                        KIND_QUERY: begin
                            if (i_status.len_zero) begin
                                o_cmd.emit_empty = 1'b1;
                            end else begin
                                o_cmd.latch_query = 1'b1;
                                if (i_status.hint_full) begin
                                    o_cmd.set_full = 1'b1;
                                    n_issuing      = 1'b1;
                                    n_state        = S_NEAR;
                                end else begin
                                    o_cmd.load_hint = 1'b1;
                                    n_state         = S_HINT_ISSUE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_HINT_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_state     = S_HINT_WAIT;
            end
            S_HINT_WAIT: begin
                if (i_status.dist_valid) begin
                    if (i_status.jump_far) begin
                        o_cmd.set_full = 1'b1;
                    end else begin
                        o_cmd.set_window = 1'b1;
                    end
                    n_issuing = 1'b1;
                    n_state   = S_NEAR;
                end
            end
            S_NEAR: begin
                o_cmd.issue = r_issuing;
                if (r_issuing && i_status.issue_last) begin
                    n_issuing = 1'b0;
                end
                if (i_status.dist_valid) begin
                    o_cmd.take_best = i_status.near_better;
                    if (i_status.dist_last) begin
                        o_cmd.start_look = 1'b1;
                        n_issuing        = 1'b1;
                        n_state          = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (i_status.dist_valid && (i_status.la_hit || i_status.dist_last)) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.flush = 1'b1;
                    n_issuing   = 1'b0;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.issue = r_issuing;
                    if (r_issuing && i_status.issue_last) begin
                        n_issuing = 1'b0;
                    end
                end
            end
            default: begin
                n_state   = S_IDLE;
                n_issuing = 1'b0;
            end
        endcase
    end

    a_issue_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_state == S_HINT_ISSUE || r_state == S_NEAR || r_state == S_LOOK))
        else $error("waypoint read issued outside a scan");

    a_dist_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.dist_valid |-> (r_state == S_HINT_WAIT || r_state == S_NEAR
                                 || r_state == S_LOOK))
        else $error("distance arrived while no scan was waiting for it");

    a_emit_ends_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE && !r_issuing))
        else $error("controller kept working after posting a result");

    a_hint_read_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HINT_ISSUE) |=> (r_state == S_HINT_WAIT && !o_cmd.issue))
        else $error("hint check read more than one waypoint");

endmodule
